@@ rtl/core/pct_pkg.sv @@
`timescale 1ns / 1ps
package pct_pkg;

   localparam int PEER_ENTRIES = 16;
   localparam int IDX_W = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
   localparam int CNT_W = $clog2(PEER_ENTRIES + 1);
   localparam int MAX_HEARTBEATS = 16;
   localparam int HB_W = $clog2(MAX_HEARTBEATS + 1);

   localparam logic [2:0] KIND_PUB = 3'd0;
   localparam logic [2:0] KIND_STATE = 3'd1;
   localparam logic [2:0] KIND_HB = 3'd2;
   localparam logic [2:0] KIND_FWD = 3'd3;
   localparam logic [2:0] KIND_TICK = 3'd4;
   localparam logic [2:0] KIND_QUERY = 3'd5;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOCHANGE = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_MISMATCH = 3'd3;
   localparam logic [2:0] ST_FULL = 3'd4;
   localparam logic [2:0] ST_DISABLED = 3'd5;

   localparam logic [2:0] CS_INIT = 3'd0;
   localparam logic [2:0] CS_PREPARING = 3'd1;
   localparam logic [2:0] CS_SYNC = 3'd2;
   localparam logic [2:0] CS_CONNECTING = 3'd3;
   localparam logic [2:0] CS_CONNECTED = 3'd4;
   localparam logic [2:0] CS_FAILED = 3'd5;

   localparam logic [2:0] REG_ENABLE = 3'd0;
   localparam logic [2:0] REG_PREP = 3'd1;
   localparam logic [2:0] REG_SYNC = 3'd2;
   localparam logic [2:0] REG_CONNECTING = 3'd3;
   localparam logic [2:0] REG_CONNECTED = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   // One classified event handed from front to back
   typedef struct packed {
      logic [2:0] kind;
      logic [31:0] tun_ip;
      logic [31:0] pub_ip;
      logic [15:0] pub_port;
      logic force_sync;
   } event_type;

   typedef struct packed {
      logic enable;
      logic [7:0] preparing_limit;
      logic [7:0] sync_limit;
      logic [7:0] connecting_limit;
      logic [7:0] connected_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] peer_state;
      logic send_heartbeat;
      logic [31:0] dest_ip;
      logic [15:0] dest_port;
      logic last;
   } result_type;

endpackage

@@ rtl/core/peer_connection_tracker.sv @@
`timescale 1ns / 1ps
// A two-entry queue decouples acceptance from execution; the back end captures an
// item into its event register only when idle and registers a direct result into
// the output register. An enabled tick walks the table one entry per cycle, holding
// while a heartbeat waits for the output. Reset (synchronous, active high) clears
// the queue and all valid bits and sets the configuration registers to defaults.
module peer_connection_tracker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_kind,
   input  logic [31:0] req_tun_ip,
   input  logic [31:0] req_pub_ip,
   input  logic [15:0] req_pub_port,
   input  logic req_force_sync,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_status,
   output logic [2:0] rsp_peer_state,
   output logic rsp_send_heartbeat,
   output logic [31:0] rsp_dest_ip,
   output logic [15:0] rsp_dest_port,
   output logic rsp_last,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import pct_pkg::*;

   cfg_type cfg_ff;
   logic ev_valid, ev_ready;
   event_type ev_data;
   result_type rsp_data;
   logic [2:0] reg_idx;

   assign pready = 1'b1;
   assign reg_idx = paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{enable: 1'b0, preparing_limit: 8'd30, sync_limit: 8'd10,
                     connecting_limit: 8'd60, connected_limit: 8'd2};
      end else if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_ENABLE: cfg_ff.enable <= pwdata[0];
            REG_PREP: cfg_ff.preparing_limit <= pwdata[7:0];
            REG_SYNC: cfg_ff.sync_limit <= pwdata[7:0];
            REG_CONNECTING: cfg_ff.connecting_limit <= pwdata[7:0];
            REG_CONNECTED: cfg_ff.connected_limit <= pwdata[7:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_idx)
         REG_ENABLE: prdata = {31'd0, cfg_ff.enable};
         REG_PREP: prdata = {24'd0, cfg_ff.preparing_limit};
         REG_SYNC: prdata = {24'd0, cfg_ff.sync_limit};
         REG_CONNECTING: prdata = {24'd0, cfg_ff.connecting_limit};
         REG_CONNECTED: prdata = {24'd0, cfg_ff.connected_limit};
         default: prdata = 32'd0;
      endcase
   end

   pct_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_tun_ip, .req_pub_ip,
      .req_pub_port, .req_force_sync, .ev_valid, .ev_ready, .ev_data
   );

   pct_back u_back (
      .clock, .reset, .cfg(cfg_ff), .ev_valid, .ev_ready, .ev_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   assign rsp_status = rsp_data.status;
   assign rsp_peer_state = rsp_data.peer_state;
   assign rsp_send_heartbeat = rsp_data.send_heartbeat;
   assign rsp_dest_ip = rsp_data.dest_ip;
   assign rsp_dest_port = rsp_data.dest_port;
   assign rsp_last = rsp_data.last;

   a_hb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_heartbeat |-> !rsp_last)
      else $error("heartbeat result marked last");
   a_hb_zero_other: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_send_heartbeat |-> rsp_dest_ip == 32'd0 && rsp_dest_port == 16'd0)
      else $error("destination set on non-heartbeat result");
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

@@ rtl/core/pct_front.sv @@
`timescale 1ns / 1ps
module pct_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [2:0] req_kind,
   input  logic [31:0] req_tun_ip,
   input  logic [31:0] req_pub_ip,
   input  logic [15:0] req_pub_port,
   input  logic req_force_sync,
   output logic ev_valid,
   input  logic ev_ready,
   output pct_pkg::event_type ev_data
);
   import pct_pkg::*;

   event_type q_ff [QUEUE_DEPTH];
   logic wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign ev_valid = (count_ff != 2'd0);
   assign ev_data = q_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop = ev_valid && ev_ready;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // store the item in the queue
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{kind: req_kind, tun_ip: req_tun_ip, pub_ip: req_pub_ip,
                              pub_port: req_pub_port, force_sync: req_force_sync};
      end
   end
endmodule

@@ rtl/core/pct_back.sv @@
`timescale 1ns / 1ps
module pct_back (
   input  logic clock,
   input  logic reset,
   input  pct_pkg::cfg_type cfg,
   input  logic ev_valid,
   output logic ev_ready,
   input  pct_pkg::event_type ev_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output pct_pkg::result_type rsp_data
);
   import pct_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_WALK = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [PEER_ENTRIES-1:0] valid_ff;
   logic [31:0] tip_ff [PEER_ENTRIES];
   logic [31:0] pip_ff [PEER_ENTRIES];
   logic [15:0] port_ff [PEER_ENTRIES];
   logic [2:0] cs_ff [PEER_ENTRIES];
   logic [7:0] tc_ff [PEER_ENTRIES];

   event_type ev_ff;
   logic [CNT_W-1:0] walk_ff;
   logic [HB_W-1:0] hb_ff;
   logic out_valid_ff;
   result_type out_ff;

   // lookup
   logic hit;
   logic [IDX_W-1:0] hit_idx;
   logic free;
   logic [IDX_W-1:0] free_idx;

   always_comb begin
      hit = 1'b0;
      hit_idx = '0;
      free = 1'b0;
      free_idx = '0;
      for (int i = PEER_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && tip_ff[i] == ev_ff.tun_ip) begin
            hit = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // per-event decision
   logic [IDX_W-1:0] idx;
   logic [2:0] cur_cs;
   logic [31:0] cur_pip;
   logic [15:0] cur_port;
   logic found;
   logic take, wr_pub, wr_tc, wr_cs, wr_port;
   logic [2:0] new_cs;
   result_type res;

   always_comb begin
      idx = hit ? hit_idx : free_idx;
      found = hit;
      cur_cs = hit ? cs_ff[idx] : CS_INIT;
      cur_pip = hit ? pip_ff[idx] : 32'd0;
      cur_port = hit ? port_ff[idx] : 16'd0;
      take = 1'b0;
      wr_pub = 1'b0;
      wr_tc = 1'b0;
      wr_cs = 1'b0;
      wr_port = 1'b0;
      new_cs = cur_cs;
      res = '{status: ST_OK, peer_state: CS_INIT, send_heartbeat: 1'b0,
              dest_ip: 32'd0, dest_port: 16'd0, last: 1'b1};
      if (!cfg.enable && (ev_ff.kind == KIND_PUB || ev_ff.kind == KIND_STATE ||
                          ev_ff.kind == KIND_HB || ev_ff.kind == KIND_TICK)) begin
         res.status = ST_DISABLED;
      end else begin
         case (ev_ff.kind)
            KIND_PUB, KIND_STATE: begin
               if (!hit && !free) begin
                  res.status = ST_FULL;
               end else begin
                  take = !hit;
                  if (ev_ff.kind == KIND_PUB) begin
                     if (ev_ff.force_sync || cur_cs == CS_INIT || cur_cs == CS_FAILED)
                        new_cs = CS_SYNC;
                     else if (cur_cs == CS_PREPARING)
                        new_cs = CS_CONNECTING;
                  end else begin
                     if (cur_cs == CS_INIT)
                        new_cs = CS_PREPARING;
                     else if (cur_cs == CS_SYNC)
                        new_cs = CS_CONNECTING;
                  end
                  if (new_cs == cur_cs && !(ev_ff.kind == KIND_PUB && ev_ff.force_sync)) begin
                     res.status = ST_NOCHANGE;
                  end else begin
                     wr_cs = 1'b1;
                     wr_tc = 1'b1;
                     wr_pub = (ev_ff.kind == KIND_PUB);
                  end
                  res.peer_state = new_cs;
               end
            end
            KIND_HB: begin
               if (!found) begin
                  res.status = ST_UNKNOWN;
               end else if (cur_pip != ev_ff.pub_ip) begin
                  res.status = ST_MISMATCH;
                  res.peer_state = cur_cs;
               end else begin
                  new_cs = CS_CONNECTED;
                  wr_cs = 1'b1;
                  wr_tc = 1'b1;
                  wr_port = 1'b1;
                  res.peer_state = CS_CONNECTED;
               end
            end
            KIND_FWD: begin
               if (!found) begin
                  res.status = ST_UNKNOWN;
               end else begin
                  res.peer_state = cur_cs;
                  if (cur_pip != ev_ff.pub_ip || cur_port != ev_ff.pub_port)
                     res.status = ST_MISMATCH;
               end
            end
            KIND_QUERY: begin
               if (!cfg.enable) begin
                  res.status = ST_DISABLED;
                  res.peer_state = CS_FAILED;
               end else if (!found) begin
                  res.status = ST_UNKNOWN;
               end else begin
                  res.peer_state = cur_cs;
               end
            end
            default: res.status = ST_NOCHANGE;
         endcase
      end
   end

   // tick walk over one entry per cycle, holding while a heartbeat waits for the output
   logic [IDX_W-1:0] w_idx;
   logic [2:0] w_s;
   logic [7:0] w_t;
   logic w_live, w_timeout, w_hb;
   logic [2:0] w_ns;

   always_comb begin
      w_idx = walk_ff[IDX_W-1:0];
      w_s = cs_ff[w_idx];
      w_t = tc_ff[w_idx];
      w_live = valid_ff[w_idx] && (w_s == CS_PREPARING || w_s == CS_SYNC ||
                                   w_s == CS_CONNECTING || w_s == CS_CONNECTED);
      w_timeout = 1'b0;
      w_ns = w_s;
      case (w_s)
         CS_PREPARING: begin
            w_timeout = w_t > cfg.preparing_limit;
            w_ns = CS_FAILED;
         end
         CS_SYNC: begin
            w_timeout = w_t > cfg.sync_limit;
            w_ns = CS_INIT;
         end
         CS_CONNECTING: begin
            w_timeout = w_t > cfg.connecting_limit;
            w_ns = CS_FAILED;
         end
         CS_CONNECTED: begin
            w_timeout = w_t > cfg.connected_limit;
            w_ns = CS_INIT;
         end
         default: w_timeout = 1'b0;
      endcase
      w_hb = w_live && !w_timeout && (w_s == CS_CONNECTING || w_s == CS_CONNECTED) &&
             (hb_ff < HB_W'(MAX_HEARTBEATS));
   end

   logic out_free;
   logic out_load;
   assign out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_ff;
   assign ev_ready = (state_ff == S_IDLE);

   // load the output register from whichever stage has a result ready
   assign out_load = out_free &&
                     ((state_ff == S_EXEC && !(ev_ff.kind == KIND_TICK && cfg.enable)) ||
                      (state_ff == S_WALK && w_hb) ||
                      (state_ff == S_OUT));

   // sequence each event
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (ev_valid) state_in = S_EXEC;
         S_EXEC: begin
            if (ev_ff.kind == KIND_TICK && cfg.enable) state_in = S_WALK;
            else if (out_free) state_in = S_IDLE;
         end
         S_WALK: begin
            if (!(w_hb && !out_free) && walk_ff == CNT_W'(PEER_ENTRIES - 1))
               state_in = S_OUT;
         end
         S_OUT: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         out_valid_ff <= 1'b0;
         walk_ff <= '0;
         hb_ff <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_load || (out_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               walk_ff <= '0;
               hb_ff <= '0;
            end
            S_EXEC: begin
               if (out_load && take) valid_ff[idx] <= 1'b1;
            end
            S_WALK: begin
               // hold while a heartbeat cannot be placed
               if (!(w_hb && !out_free)) begin
                  if (w_hb) hb_ff <= hb_ff + HB_W'(1);
                  walk_ff <= walk_ff + CNT_W'(1);
               end
            end
            default: ;
         endcase
      end
   end

   // entry and payload writes
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && ev_valid) ev_ff <= ev_data;
      if (state_ff == S_EXEC && !(ev_ff.kind == KIND_TICK && cfg.enable) && out_free) begin
         out_ff <= res;
         // a taken entry gets its new state and a cleared address unless the event writes one
         if (take) tip_ff[idx] <= ev_ff.tun_ip;
         if (take || wr_cs) cs_ff[idx] <= wr_cs ? new_cs : CS_INIT;
         if (take || wr_tc) tc_ff[idx] <= 8'd0;
         if (take || wr_pub) pip_ff[idx] <= wr_pub ? ev_ff.pub_ip : 32'd0;
         if (take || wr_pub || wr_port)
            port_ff[idx] <= (wr_pub || wr_port) ? ev_ff.pub_port : 16'd0;
      end
      if (state_ff == S_WALK && !(w_hb && !out_free) && w_live) begin
         if (w_timeout) cs_ff[w_idx] <= w_ns;
         else if (w_t != 8'hFF) tc_ff[w_idx] <= w_t + 8'd1;
         if (w_hb) begin
            out_ff <= '{status: ST_OK, peer_state: w_s, send_heartbeat: 1'b1,
                        dest_ip: pip_ff[w_idx], dest_port: port_ff[w_idx], last: 1'b0};
         end
      end
      if (state_ff == S_OUT && out_free) begin
         out_ff <= '{status: ST_OK, peer_state: CS_INIT, send_heartbeat: 1'b0,
                     dest_ip: 32'd0, dest_port: 16'd0, last: 1'b1};
      end
   end
endmodule

@@ tb/peer_connection_tracker_test.sv @@
`timescale 1ns / 1ps
module peer_connection_tracker_test;
   import pct_pkg::*;

   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam logic [2:0] REG_UNUSED = 3'd5;
   localparam int NKEYS = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [2:0] req_kind = '0;
   logic [31:0] req_tun_ip = '0;
   logic [31:0] req_pub_ip = '0;
   logic [15:0] req_pub_port = '0;
   logic req_force_sync = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [2:0] rsp_peer_state;
   logic rsp_send_heartbeat;
   logic [31:0] rsp_dest_ip;
   logic [15:0] rsp_dest_port;
   logic rsp_last;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   peer_connection_tracker u_top (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow table and registers
   cfg_type cfg;
   logic peer_used [PEER_ENTRIES];
   logic [31:0] peer_tun [PEER_ENTRIES];
   logic [31:0] peer_pip [PEER_ENTRIES];
   logic [15:0] peer_port [PEER_ENTRIES];
   logic [2:0] peer_cs [PEER_ENTRIES];
   logic [7:0] peer_ticks [PEER_ENTRIES];

   event_type pending_items [$];
   result_type expected_results [$];
   int fail_count = 0;
   int sender_idle = 11;
   int receiver_idle = 71;
   logic req_taken = 1'b0;

   logic [31:0] keys [NKEYS];
   logic [31:0] key_pip [NKEYS];
   logic [15:0] key_port [NKEYS];

   function automatic void expect_result(logic [2:0] st, logic [2:0] cs, logic hb,
                                         logic [31:0] ip, logic [15:0] port, logic lst);
      result_type r;
      r.status = st;
      r.peer_state = cs;
      r.send_heartbeat = hb;
      r.dest_ip = ip;
      r.dest_port = port;
      r.last = lst;
      expected_results = {expected_results, r};
   endfunction

   function automatic int lookup_peer(logic [31:0] k);
      for (int i = 0; i < PEER_ENTRIES; i++)
         if (peer_used[i] && peer_tun[i] == k) return i;
      return -1;
   endfunction

   function automatic int lookup_or_claim(logic [31:0] k);
      int i;
      i = lookup_peer(k);
      if (i >= 0) return i;
      for (int j = 0; j < PEER_ENTRIES; j++) begin
         if (!peer_used[j]) begin
            peer_used[j] = 1'b1;
            peer_tun[j] = k;
            peer_pip[j] = '0;
            peer_port[j] = '0;
            peer_cs[j] = CS_INIT;
            peer_ticks[j] = '0;
            return j;
         end
      end
      return -1;
   endfunction

   // walk the table for one tick
   function automatic void walk_tick();
      int n;
      logic [2:0] s;
      logic [7:0] t;
      n = 0;
      for (int i = 0; i < PEER_ENTRIES; i++) begin
         if (!peer_used[i]) continue;
         s = peer_cs[i];
         t = peer_ticks[i];
         if (s == CS_INIT || s == CS_FAILED || s > CS_FAILED) continue;
         if (s == CS_PREPARING && t > cfg.preparing_limit) begin
            peer_cs[i] = CS_FAILED;
            continue;
         end
         if (s == CS_SYNC && t > cfg.sync_limit) begin
            peer_cs[i] = CS_INIT;
            continue;
         end
         if (s == CS_CONNECTING && t > cfg.connecting_limit) begin
            peer_cs[i] = CS_FAILED;
            continue;
         end
         if (s == CS_CONNECTED && t > cfg.connected_limit) begin
            peer_cs[i] = CS_INIT;
            continue;
         end
         if ((s == CS_CONNECTING || s == CS_CONNECTED) && n < MAX_HEARTBEATS) begin
            expect_result(ST_OK, s, 1'b1, peer_pip[i], peer_port[i], 1'b0);
            n++;
         end
         if (t != 8'hFF) peer_ticks[i] = t + 8'd1;
      end
      expect_result(ST_OK, CS_INIT, 1'b0, '0, '0, 1'b1);
   endfunction

   // work out the results of one accepted item
   function automatic void predict_tracker(event_type e);
      int i;
      logic [2:0] s;
      if (!cfg.enable && (e.kind <= KIND_HB || e.kind == KIND_TICK)) begin
         expect_result(ST_DISABLED, CS_INIT, 1'b0, '0, '0, 1'b1);
         return;
      end
      case (e.kind)
         KIND_PUB, KIND_STATE: begin
            i = lookup_or_claim(e.tun_ip);
            if (i < 0) begin
               expect_result(ST_FULL, CS_INIT, 1'b0, '0, '0, 1'b1);
               return;
            end
            s = peer_cs[i];
            if (e.kind == KIND_PUB) begin
               if (e.force_sync || s == CS_INIT || s == CS_FAILED) s = CS_SYNC;
               else if (s == CS_PREPARING) s = CS_CONNECTING;
               else begin
                  expect_result(ST_NOCHANGE, s, 1'b0, '0, '0, 1'b1);
                  return;
               end
               peer_pip[i] = e.pub_ip;
               peer_port[i] = e.pub_port;
            end else begin
               if (s == CS_INIT) s = CS_PREPARING;
               else if (s == CS_SYNC) s = CS_CONNECTING;
               else begin
                  expect_result(ST_NOCHANGE, s, 1'b0, '0, '0, 1'b1);
                  return;
               end
            end
            peer_cs[i] = s;
            peer_ticks[i] = '0;
            expect_result(ST_OK, s, 1'b0, '0, '0, 1'b1);
         end
         KIND_HB: begin
            i = lookup_peer(e.tun_ip);
            if (i < 0) expect_result(ST_UNKNOWN, CS_INIT, 1'b0, '0, '0, 1'b1);
            else if (peer_pip[i] != e.pub_ip)
               expect_result(ST_MISMATCH, peer_cs[i], 1'b0, '0, '0, 1'b1);
            else begin
               peer_port[i] = e.pub_port;
               peer_ticks[i] = '0;
               peer_cs[i] = CS_CONNECTED;
               expect_result(ST_OK, CS_CONNECTED, 1'b0, '0, '0, 1'b1);
            end
         end
         KIND_FWD: begin
            i = lookup_peer(e.tun_ip);
            if (i < 0) expect_result(ST_UNKNOWN, CS_INIT, 1'b0, '0, '0, 1'b1);
            else if (peer_pip[i] != e.pub_ip || peer_port[i] != e.pub_port)
               expect_result(ST_MISMATCH, peer_cs[i], 1'b0, '0, '0, 1'b1);
            else expect_result(ST_OK, peer_cs[i], 1'b0, '0, '0, 1'b1);
         end
         KIND_TICK: walk_tick();
         KIND_QUERY: begin
            if (!cfg.enable) expect_result(ST_DISABLED, CS_FAILED, 1'b0, '0, '0, 1'b1);
            else begin
               i = lookup_peer(e.tun_ip);
               if (i < 0) expect_result(ST_UNKNOWN, CS_INIT, 1'b0, '0, '0, 1'b1);
               else expect_result(ST_OK, peer_cs[i], 1'b0, '0, '0, 1'b1);
            end
         end
         default: expect_result(ST_NOCHANGE, CS_INIT, 1'b0, '0, '0, 1'b1);
      endcase
   endfunction

   // drive the request channel and the result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle);
         if (!req_valid || req_taken) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
               event_type e;
               e = pending_items.pop_front();
               req_kind <= e.kind;
               req_tun_ip <= e.tun_ip;
               req_pub_ip <= e.pub_ip;
               req_pub_port <= e.pub_port;
               req_force_sync <= e.force_sync;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // predict on acceptance, check each result against the oldest expectation
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         event_type e;
         e.kind = req_kind;
         e.tun_ip = req_tun_ip;
         e.pub_ip = req_pub_ip;
         e.pub_port = req_pub_port;
         e.force_sync = req_force_sync;
         predict_tracker(e);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result item");
            fail_count++;
         end else begin
            result_type x;
            x = expected_results.pop_front();
            if (x.status !== rsp_status) begin
               $error("status: expected %0d, got %0d", x.status, rsp_status);
               fail_count++;
            end
            if (x.peer_state !== rsp_peer_state) begin
               $error("peer_state: expected %0d, got %0d", x.peer_state, rsp_peer_state);
               fail_count++;
            end
            if (x.send_heartbeat !== rsp_send_heartbeat) begin
               $error("send_heartbeat: expected %0d, got %0d", x.send_heartbeat,
                      rsp_send_heartbeat);
               fail_count++;
            end
            if (x.dest_ip !== rsp_dest_ip) begin
               $error("dest_ip: expected %h, got %h", x.dest_ip, rsp_dest_ip);
               fail_count++;
            end
            if (x.dest_port !== rsp_dest_port) begin
               $error("dest_port: expected %h, got %h", x.dest_port, rsp_dest_port);
               fail_count++;
            end
            if (x.last !== rsp_last) begin
               $error("last: expected %0d, got %0d", x.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (idx)
         REG_ENABLE: cfg.enable = value[0];
         REG_PREP: cfg.preparing_limit = value[7:0];
         REG_SYNC: cfg.sync_limit = value[7:0];
         REG_CONNECTING: cfg.connecting_limit = value[7:0];
         REG_CONNECTED: cfg.connected_limit = value[7:0];
         default: ;
      endcase
   endtask

   // hold until every item is in and every result out, then let the walk settle
   task automatic drain();
      wait (pending_items.size() == 0 && !req_valid && expected_results.size() == 0);
      repeat (2 * PEER_ENTRIES + 8) @(posedge clock);
   endtask

   task automatic add_item(logic [2:0] k, int ki, logic [31:0] pip, logic [15:0] port,
                           logic frc);
      event_type e;
      e.kind = k;
      e.tun_ip = keys[ki];
      e.pub_ip = pip;
      e.pub_port = port;
      e.force_sync = frc;
      pending_items = {pending_items, e};
   endtask

   // mostly well-formed traffic on a small key pool, with some noise
   task automatic add_random(int n);
      int ki, r;
      logic [2:0] k;
      logic [31:0] pip;
      logic [15:0] port;
      for (int j = 0; j < n; j++) begin
         ki = $urandom_range(0, NKEYS - 1);
         r = $urandom_range(0, 99);
         if (r < 20) k = KIND_PUB;
         else if (r < 40) k = KIND_STATE;
         else if (r < 60) k = KIND_HB;
         else if (r < 72) k = KIND_FWD;
         else if (r < 87) k = KIND_TICK;
         else if (r < 97) k = KIND_QUERY;
         else k = (r == 97) ? KIND_SPARE6 : KIND_SPARE7;
         pip = ($urandom_range(0, 99) < 80) ? key_pip[ki] : $urandom;
         port = ($urandom_range(0, 99) < 80) ? key_port[ki] : 16'($urandom);
         add_item(k, ki, pip, port, $urandom_range(0, 99) < 25);
      end
   endtask

   initial begin
      cfg.enable = 1'b0;
      cfg.preparing_limit = 8'd30;
      cfg.sync_limit = 8'd10;
      cfg.connecting_limit = 8'd60;
      cfg.connected_limit = 8'd2;
      for (int i = 0; i < PEER_ENTRIES; i++) peer_used[i] = 1'b0;
      for (int i = 0; i < NKEYS; i++) begin
         keys[i] = $urandom;
         key_pip[i] = $urandom;
         key_port[i] = 16'($urandom);
      end
      keys[0] = '0;
      keys[1] = 32'hFFFF_FFFF;
      key_pip[0] = 32'hFFFF_FFFF;
      key_port[0] = 16'hFFFF;
      key_pip[1] = '0;
      key_port[1] = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // disabled after reset
      add_item(KIND_PUB, 0, key_pip[0], key_port[0], 1'b1);
      add_item(KIND_STATE, 0, '0, '0, 1'b0);
      add_item(KIND_HB, 0, key_pip[0], key_port[0], 1'b0);
      add_item(KIND_TICK, 0, '0, '0, 1'b0);
      add_item(KIND_QUERY, 0, '0, '0, 1'b0);
      add_item(KIND_FWD, 0, '0, '0, 1'b0);
      drain();
      csr_write(REG_ENABLE, 32'd1);
      csr_write(REG_UNUSED, 32'hFFFF_FFFF);

      // directed walk through every event kind and the ok, no-change, unknown and mismatch outcomes
      add_item(KIND_QUERY, 0, '0, '0, 1'b0);
      add_item(KIND_HB, 0, '0, '0, 1'b0);
      add_item(KIND_FWD, 0, '0, '0, 1'b0);
      add_item(KIND_PUB, 0, key_pip[0], key_port[0], 1'b0);
      add_item(KIND_STATE, 0, '0, '0, 1'b0);
      add_item(KIND_FWD, 0, key_pip[0], key_port[0], 1'b0);
      add_item(KIND_FWD, 0, key_pip[0], ~key_port[0], 1'b0);
      add_item(KIND_TICK, 0, '0, '0, 1'b0);
      add_item(KIND_HB, 0, ~key_pip[0], key_port[0], 1'b0);
      add_item(KIND_HB, 0, key_pip[0], 16'h0000, 1'b0);
      add_item(KIND_TICK, 0, '0, '0, 1'b0);
      add_item(KIND_STATE, 0, '0, '0, 1'b0);
      add_item(KIND_PUB, 0, key_pip[0], key_port[0], 1'b0);
      add_item(KIND_PUB, 0, key_pip[0], key_port[0], 1'b1);
      add_item(KIND_STATE, 1, '0, '0, 1'b0);
      add_item(KIND_PUB, 1, key_pip[1], key_port[1], 1'b0);
      add_item(KIND_QUERY, 1, '0, '0, 1'b0);
      add_item(KIND_SPARE6, 1, '0, '0, 1'b0);
      add_item(KIND_SPARE7, 1, '0, '0, 1'b0);
      add_item(KIND_TICK, 0, '0, '0, 1'b0);
      drain();

      // random traffic, sender idling lightly and receiver heavily
      sender_idle = 11;
      receiver_idle = 71;
      add_random(30);
      drain();

      // extreme limits: everything but connected times out once its tick count passes zero
      csr_write(REG_PREP, 32'd0);
      csr_write(REG_SYNC, 32'd0);
      csr_write(REG_CONNECTING, 32'd0);
      csr_write(REG_CONNECTED, 32'd255);
      sender_idle = 71;
      receiver_idle = 11;
      add_random(30);
      drain();

      csr_write(REG_PREP, $urandom_range(0, 255));
      csr_write(REG_SYNC, $urandom_range(0, 255));
      csr_write(REG_CONNECTING, 32'd255);
      csr_write(REG_CONNECTED, $urandom_range(0, 7));
      sender_idle = 0;
      receiver_idle = 0;
      add_random(30);
      drain();

      // saturate tick counts with no timeouts
      csr_write(REG_PREP, 32'd255);
      csr_write(REG_SYNC, 32'd255);
      csr_write(REG_CONNECTED, 32'd255);
      for (int i = 2; i < NKEYS; i++) add_item(KIND_HB, i, key_pip[i], key_port[i], 1'b0);
      for (int i = 0; i < 262; i++) add_item(KIND_TICK, 0, '0, '0, 1'b0);
      add_random(10);
      drain();

      csr_write(REG_ENABLE, 32'd0);
      add_random(10);
      drain();

      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pct_pkg.sv
rtl/core/pct_front.sv
rtl/core/pct_back.sv
rtl/core/peer_connection_tracker.sv
tb/peer_connection_tracker_test.sv
